// ----- sv/masked_alpha_pixel_blend_assert.svh -----
// Assertion macros shared by the checker of the pixel blend.
// No dependencies; include once per file that asserts.
`ifndef MASKED_ALPHA_PIXEL_BLEND_ASSERT_SVH
`define MASKED_ALPHA_PIXEL_BLEND_ASSERT_SVH

// same-cycle implication
`define MAPB_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error(msg);

// next-cycle implication
`define MAPB_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error(msg);

`endif

// ----- sv/mapb_pkg.sv -----
// Shared types and constants of the masked alpha pixel blend.
// No dependencies.
package mapb_pkg;

	localparam logic [7:0]  FULL_SCALE = 8'd255;
	localparam logic [16:0] Q16_ONE    = 17'h10000;
	localparam int          CFG_W      = 17;
	localparam int          RECIP_W    = 17;

	localparam logic [1:0] REG_USE_MASK     = 2'd0;
	localparam logic [1:0] REG_OPACITY      = 2'd1;
	localparam logic [1:0] REG_LAYER_MAXVAL = 2'd2;
	localparam logic [1:0] REG_MASK_MAXVAL  = 2'd3;

	// per-stage load strobes
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
	} stage_en_t;

endpackage

// ----- sv/mapb_rescale.sv -----
// One sample lane of the v*255/maxval rescale, stages 1..3.
// Reciprocal multiply then one-step remainder fix. Depends on mapb_pkg.
module mapb_rescale (
	input  logic                         clk,
	input  mapb_pkg::stage_en_t          en,
	input  logic [7:0]                   v,
	input  logic [7:0]                   maxval,
	input  logic [mapb_pkg::RECIP_W-1:0] recip,
	output logic [7:0]                   q
);
	import mapb_pkg::*;

	logic [15:0] x_s1, x_s2;
	logic [7:0]  v_s1, v_s2, q_s3;
	logic [16:0] qe_s2;
	logic [32:0] prod;
	logic [24:0] back, rem;
	logic        corr;

	// x = v*255
	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			x_s1 <= {v, 8'd0} - {8'd0, v};
			v_s1 <= v;
		end
	end

	// estimate is exact or one low
	assign prod = 33'(x_s1) * 33'(recip);

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			qe_s2 <= prod[32:16];
			x_s2  <= x_s1;
			v_s2  <= v_s1;
		end
	end

	assign back = 25'(qe_s2) * 25'(maxval);
	assign rem  = 25'(x_s2) - back;
	assign corr = rem >= 25'(maxval);

	// maxval of zero passes the raw sample
	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			q_s3 <= (maxval == 8'd0) ? v_s2 : qe_s2[7:0] + {7'd0, corr};
		end
	end

	assign q = q_s3;

endmodule

// ----- sv/mapb_blend.sv -----
// Coefficient, multiply-accumulate and normalize stages 4..6 of the blend.
// Depends on mapb_pkg.
module mapb_blend (
	input  logic                clk,
	input  mapb_pkg::stage_en_t en,
	input  logic                use_mask,
	input  logic [16:0]         opacity,
	input  logic [2:0][7:0]     dst,
	input  logic [2:0][7:0]     src,
	input  logic [7:0]          mask,
	output logic [2:0][7:0]     res
);
	import mapb_pkg::*;

	function automatic logic [7:0] div_by_255(input logic [15:0] x);
		logic [24:0] p;
		logic [8:0]  qe;
		logic [16:0] rem;
		p   = {1'b0, x, 8'd0} + {9'd0, x};
		qe  = p[24:16];
		rem = {1'b0, x} - (17'({qe, 8'd0}) - 17'(qe));
		return (rem >= 17'(FULL_SCALE)) ? qe[7:0] + 8'd1 : qe[7:0];
	endfunction

	logic            full;
	logic [24:0]     mprod;
	logic [7:0]      c1;
	logic [7:0]      c0_s4, c1_s4;
	logic [2:0][7:0] dst_s4, src_s4, dst_s5, src_s5, res_s6;
	logic [2:0][15:0] acc_s5;
	logic            copy_s4, keep_s4, div255_s4;
	logic            copy_s5, keep_s5, div255_s5;

	assign full  = opacity == Q16_ONE;
	assign mprod = 25'(mask) * 25'(opacity);
	assign c1    = full ? mask : mprod[23:16];

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			c1_s4     <= c1;
			c0_s4     <= FULL_SCALE - c1;
			dst_s4    <= dst;
			src_s4    <= src;
			copy_s4   <= !use_mask || (full && mask == FULL_SCALE);
			keep_s4   <= mask == 8'd0;
			div255_s4 <= full;
		end
	end

	// c0+c1 = 255 keeps the sum inside 16 bits
	always_ff @(posedge clk) begin
		if (en.ld_s5) begin
			for (int i = 0; i < 3; i++) begin
				acc_s5[i] <= 16'({8'd0, dst_s4[i]} * {8'd0, c0_s4})
					+ 16'({8'd0, src_s4[i]} * {8'd0, c1_s4});
			end
			dst_s5    <= dst_s4;
			src_s5    <= src_s4;
			copy_s5   <= copy_s4;
			keep_s5   <= keep_s4;
			div255_s5 <= div255_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s6) begin
			for (int i = 0; i < 3; i++) begin
				if (copy_s5) begin
					res_s6[i] <= src_s5[i];
				end else if (keep_s5) begin
					res_s6[i] <= dst_s5[i];
				end else if (div255_s5) begin
					res_s6[i] <= div_by_255(acc_s5[i]);
				end else begin
					res_s6[i] <= acc_s5[i][15:8];
				end
			end
		end
	end

	assign res = res_s6;

endmodule

// ----- sv/masked_alpha_pixel_blend.sv -----
// Masked alpha blend of one RGB8 pixel per word, six register stages.
// Throughput: one word per cycle while out_stall is low.
// Each stage holds one word; the output register is stage 6.
// Stalls back up stage by stage; a bubble ahead of a stalled word is still filled.
// Reset (arst_n low, asynchronous) empties the pipeline and loads use_mask=1,
// opacity=1.0, layer and mask maxval=255.
module masked_alpha_pixel_blend (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [mapb_pkg::CFG_W-1:0] cfg_data,
	// input words
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 dst_red,
	input  logic [7:0]                 dst_green,
	input  logic [7:0]                 dst_blue,
	input  logic [7:0]                 src_red,
	input  logic [7:0]                 src_green,
	input  logic [7:0]                 src_blue,
	input  logic [7:0]                 mask_level,
	// output words
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_red,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_blue
);
	import mapb_pkg::*;

	localparam int NSTAGE = 6;

	// floor(65536/d) for every maxval; entry 0 is never used for division
	logic [RECIP_W-1:0] recip_tab [256];
	for (genvar g = 0; g < 256; g++) begin : g_recip
		localparam int R = (g == 0) ? 0 : 65536 / g;
		assign recip_tab[g] = RECIP_W'(R);
	end

	// configuration registers; reciprocals follow each maxval write
	logic               use_mask_q;
	logic [16:0]        opacity_q;
	logic [7:0]         layer_maxval_q, mask_maxval_q;
	logic [RECIP_W-1:0] layer_recip_q, mask_recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mask_q     <= 1'b1;
			opacity_q      <= Q16_ONE;
			layer_maxval_q <= FULL_SCALE;
			mask_maxval_q  <= FULL_SCALE;
			layer_recip_q  <= RECIP_W'(257);
			mask_recip_q   <= RECIP_W'(257);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USE_MASK: use_mask_q <= cfg_data[0];
				REG_OPACITY:  opacity_q  <= cfg_data[16:0];
				REG_LAYER_MAXVAL: begin
					layer_maxval_q <= cfg_data[7:0];
					layer_recip_q  <= recip_tab[cfg_data[7:0]];
				end
				REG_MASK_MAXVAL: begin
					mask_maxval_q <= cfg_data[7:0];
					mask_recip_q  <= recip_tab[cfg_data[7:0]];
				end
				default: ;
			endcase
		end
	end

	// opacity above 1.0 is clamped to 1.0
	logic [16:0] opacity_clamped;
	assign opacity_clamped = (opacity_q > Q16_ONE) ? Q16_ONE : opacity_q;

	// pipeline control: a stage loads when empty or when the next one loads
	logic [NSTAGE-1:0] stage_valid_q;
	logic [NSTAGE-1:0] stage_ready, prev_valid, stage_ld;
	stage_en_t         en;

	always_comb begin
		stage_ready[NSTAGE-1] = !stage_valid_q[NSTAGE-1] || !out_stall;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			stage_ready[k] = !stage_valid_q[k] || stage_ready[k+1];
		end
	end

	assign prev_valid = {stage_valid_q[NSTAGE-2:0], in_valid};
	assign stage_ld   = stage_ready & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			stage_valid_q <= (stage_valid_q & ~stage_ready) | (prev_valid & stage_ready);
		end
	end

	assign en.ld_s1 = stage_ld[0];
	assign en.ld_s2 = stage_ld[1];
	assign en.ld_s3 = stage_ld[2];
	assign en.ld_s4 = stage_ld[3];
	assign en.ld_s5 = stage_ld[4];
	assign en.ld_s6 = stage_ld[5];

	assign in_stall  = !stage_ready[0];
	assign out_valid = stage_valid_q[NSTAGE-1];

	// stages 1..3: rescale layer and mask samples
	logic [2:0][7:0] src_raw, src_scaled, dst_in;
	logic [7:0]      mask_scaled;

	assign src_raw = {src_blue, src_green, src_red};
	assign dst_in  = {dst_blue, dst_green, dst_red};

	for (genvar c = 0; c < 3; c++) begin : g_layer
		mapb_rescale u_rescale (
			.clk    (clk),
			.en     (en),
			.v      (src_raw[c]),
			.maxval (layer_maxval_q),
			.recip  (layer_recip_q),
			.q      (src_scaled[c])
		);
	end

	mapb_rescale u_mask_rescale (
		.clk    (clk),
		.en     (en),
		.v      (mask_level),
		.maxval (mask_maxval_q),
		.recip  (mask_recip_q),
		.q      (mask_scaled)
	);

	// composite pixel rides alongside the rescale stages
	logic [2:0][7:0] dst_s1, dst_s2, dst_s3;

	always_ff @(posedge clk) begin
		if (en.ld_s1) dst_s1 <= dst_in;
		if (en.ld_s2) dst_s2 <= dst_s1;
		if (en.ld_s3) dst_s3 <= dst_s2;
	end

	// stages 4..6: coefficients, weighted sum, normalize and select
	logic [2:0][7:0] res;

	mapb_blend u_blend (
		.clk      (clk),
		.en       (en),
		.use_mask (use_mask_q),
		.opacity  (opacity_clamped),
		.dst      (dst_s3),
		.src      (src_scaled),
		.mask     (mask_scaled),
		.res      (res)
	);

	assign out_red   = res[0];
	assign out_green = res[1];
	assign out_blue  = res[2];

endmodule

// ----- sv/masked_alpha_pixel_blend_checker.sv -----
// Port-level checker of the masked alpha pixel blend, bound to the top level.
// Depends on masked_alpha_pixel_blend_assert.svh.
`include "masked_alpha_pixel_blend_assert.svh"

module masked_alpha_pixel_blend_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	// output word still valid and unchanged since the last edge
	sequence s_out_same;
		out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue);
	endsequence

	// accepted word while out_stall is low, then out_stall kept low after it
	sequence s_free_run;
		(in_valid && !in_stall && !out_stall) ##1 !out_stall [*5];
	endsequence

	// a held output word stays put
	`MAPB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, s_out_same, "output word changed under stall")

	// input side only backs up when every stage is full behind a stalled output
	`MAPB_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled with room")

	// an accepted word reaches the output register when out_stall stays low behind it
	`MAPB_ASSERT_NEXT(a_latency, clk, arst_n, s_free_run, out_valid, "word late after six free cycles")

endmodule

bind masked_alpha_pixel_blend masked_alpha_pixel_blend_checker u_checker (.*);
